[sv/hsv_to_rgb_converter_defines.svh]
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_defines.svh
// Assertion macros shared by the HSV to RGB converter.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_DEFINES_SVH

// Checked on every rising edge, off while reset is asserted
`define HSV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge, reset included
`define HSV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[sv/hsv2rgb_pkg.sv]
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Types, constants and helpers shared by the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  // Input limits
  localparam logic [8:0] HUE_MAX = 9'd360;
  localparam logic [6:0] PCT_MAX = 7'd100;

  // Channel = floor(X * 255 / 600000) = floor((17 * X >> 6) / 625).
  // Division by 625 uses a reciprocal, exact for 18-bit operands.
  localparam logic [4:0]  CHAN_MUL = 5'd17;
  localparam logic [18:0] RECIP_M  = 19'd429497;
  localparam int unsigned RECIP_SH = 28;

  // 60-degree hue sectors
  typedef enum logic [2:0] {
    SEC_R_Y = 3'd0,
    SEC_Y_G = 3'd1,
    SEC_G_C = 3'd2,
    SEC_C_B = 3'd3,
    SEC_B_M = 3'd4,
    SEC_M_R = 3'd5
  } sector_e;

  // Output channels
  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } chan_e;

  // Component placed on a channel
  typedef enum logic [1:0] {
    SEL_ZERO   = 2'd0,
    SEL_CHROMA = 2'd1,
    SEL_SECOND = 2'd2
  } comp_sel_e;

  // Per-stage load enables
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } pipe_en_t;

  // Front-end result, units of 1/600000
  typedef struct packed {
    logic        blk;
    sector_e     sec;
    logic [19:0] chroma;
    logic [19:0] second;
    logic [19:0] offset;
  } front_t;

  // Which component a channel carries in a sector
  function automatic comp_sel_e comp_sel(input chan_e ch, input sector_e sec);
    comp_sel_e sel;
    sel = SEL_ZERO;
    case (ch)
      CH_RED: begin
        case (sec)
          SEC_R_Y, SEC_M_R: sel = SEL_CHROMA;
          SEC_Y_G, SEC_B_M: sel = SEL_SECOND;
          default:          sel = SEL_ZERO;
        endcase
      end
      CH_GREEN: begin
        case (sec)
          SEC_Y_G, SEC_G_C: sel = SEL_CHROMA;
          SEC_R_Y, SEC_C_B: sel = SEL_SECOND;
          default:          sel = SEL_ZERO;
        endcase
      end
      CH_BLUE: begin
        case (sec)
          SEC_C_B, SEC_B_M: sel = SEL_CHROMA;
          SEC_G_C, SEC_M_R: sel = SEL_SECOND;
          default:          sel = SEL_ZERO;
        endcase
      end
      default: sel = SEL_ZERO;
    endcase
    return sel;
  endfunction

endpackage

[sv/hsv2rgb_front.sv]
// ----------------------------------------------------------------------------
// hsv2rgb_front
// Stages 1-3: range check, sector decode, chroma, secondary and offset.
// ----------------------------------------------------------------------------
module hsv2rgb_front (
  input  logic                 clk_i,
  input  hsv2rgb_pkg::pipe_en_t en_i,
  input  logic [8:0]           hue_i,
  input  logic [6:0]           sat_i,
  input  logic [6:0]           val_i,
  output hsv2rgb_pkg::front_t  front_o
);

  // Stage 1 registers
  logic                 s1_blk_q;
  hsv2rgb_pkg::sector_e s1_sec_q, s1_sec_d;
  logic [5:0]           s1_k_q, s1_k_d;
  logic [6:0]           s1_sat_q, s1_val_q;

  // Stage 2 registers
  logic                 s2_blk_q;
  hsv2rgb_pkg::sector_e s2_sec_q;
  logic [5:0]           s2_k_q;
  logic [13:0]          s2_sv_q, s2_vh_q;

  // Stage 3 registers
  hsv2rgb_pkg::front_t  s3_q, s3_d;

  logic [8:0] hm;
  logic [8:0] kr;
  logic [13:0] diff;

  // Sector and distance to nearest primary, hue mod 120 by compare-subtract
  always_comb begin
    if (hue_i >= 9'd240) begin
      hm = hue_i - 9'd240;
    end else if (hue_i >= 9'd120) begin
      hm = hue_i - 9'd120;
    end else begin
      hm = hue_i;
    end
    kr = 9'd120 - hm;
    s1_k_d = (hm >= 9'd60) ? kr[5:0] : hm[5:0];

    if (hue_i < 9'd60) begin
      s1_sec_d = hsv2rgb_pkg::SEC_R_Y;
    end else if (hue_i < 9'd120) begin
      s1_sec_d = hsv2rgb_pkg::SEC_Y_G;
    end else if (hue_i < 9'd180) begin
      s1_sec_d = hsv2rgb_pkg::SEC_G_C;
    end else if (hue_i < 9'd240) begin
      s1_sec_d = hsv2rgb_pkg::SEC_C_B;
    end else if (hue_i < 9'd300) begin
      s1_sec_d = hsv2rgb_pkg::SEC_B_M;
    end else begin
      s1_sec_d = hsv2rgb_pkg::SEC_M_R;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      s1_blk_q <= (hue_i > hsv2rgb_pkg::HUE_MAX) || (sat_i > hsv2rgb_pkg::PCT_MAX) ||
                  (val_i > hsv2rgb_pkg::PCT_MAX);
      s1_sec_q <= s1_sec_d;
      s1_k_q   <= s1_k_d;
      s1_sat_q <= sat_i;
      s1_val_q <= val_i;
    end
  end

  // Stage 2: S*V and V*100
  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      s2_blk_q <= s1_blk_q;
      s2_sec_q <= s1_sec_q;
      s2_k_q   <= s1_k_q;
      s2_sv_q  <= 14'(s1_sat_q) * 14'(s1_val_q);
      s2_vh_q  <= 14'(s1_val_q) * 14'd100;
    end
  end

  // Stage 3: scale to the common denominator
  always_comb begin
    diff          = s2_vh_q - s2_sv_q;
    s3_d.blk      = s2_blk_q;
    s3_d.sec      = s2_sec_q;
    s3_d.chroma   = 20'(s2_sv_q) * 20'd60;
    s3_d.second   = 20'(s2_sv_q) * 20'(s2_k_q);
    s3_d.offset   = 20'(diff) * 20'd60;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      s3_q <= s3_d;
    end
  end

  assign front_o = s3_q;

endmodule

[sv/hsv2rgb_chan.sv]
// ----------------------------------------------------------------------------
// hsv2rgb_chan
// Stages 4-5 of one channel: component select, offset add, scale to 8 bits.
// ----------------------------------------------------------------------------
module hsv2rgb_chan (
  input  logic                 clk_i,
  input  hsv2rgb_pkg::pipe_en_t en_i,
  input  hsv2rgb_pkg::chan_e    chan_i,
  input  hsv2rgb_pkg::front_t   front_i,
  output logic [7:0]           chan_o
);

  logic [19:0] comp;
  logic [20:0] x;
  logic [25:0] y;
  logic [17:0] z_q, z_d;
  logic [36:0] p;
  logic [7:0]  q_q;

  // Stage 4: pick component, add offset, times 17 over 64
  always_comb begin
    case (hsv2rgb_pkg::comp_sel(chan_i, front_i.sec))
      hsv2rgb_pkg::SEL_CHROMA: comp = front_i.chroma;
      hsv2rgb_pkg::SEL_SECOND: comp = front_i.second;
      default:                 comp = '0;
    endcase
    x   = 21'(comp) + 21'(front_i.offset);
    y   = 26'(x) * 26'(hsv2rgb_pkg::CHAN_MUL);
    z_d = front_i.blk ? '0 : y[23:6];
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      z_q <= z_d;
    end
  end

  // Stage 5: divide by 625 via reciprocal
  assign p = 37'(z_q) * 37'(hsv2rgb_pkg::RECIP_M);

  always_ff @(posedge clk_i) begin
    if (en_i.s5) begin
      q_q <= p[hsv2rgb_pkg::RECIP_SH +: 8];
    end
  end

  assign chan_o = q_q;

endmodule

[sv/hsv_to_rgb_converter.sv]
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// HSV (degrees, percent) to 8-bit RGB, five-stage streaming pipeline.
// ----------------------------------------------------------------------------
// Accepts one color per clock while s_axis_tready_o is high and returns one
// RGB triple per color, in order. Throughput is one transfer per cycle when
// the output is not stalled, set by the five register stages, each with its
// own valid bit; s_axis_tready_o is high whenever any stage (or the output
// register) can take a new item, so bubbles are squeezed out under
// backpressure. Hue above 360 or a percentage above 100 gives black.
`include "hsv_to_rgb_converter_defines.svh"

module hsv_to_rgb_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [8:0] hue_deg, [15:9] sat_pct, [22:16] val_pct, [23] zero
  input  logic [23:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] red, [15:8] green, [23:16] blue
  output logic [23:0] m_axis_tdata_o
);

  logic [4:0] vld_q, vld_d;
  logic [4:0] rdy;
  hsv2rgb_pkg::pipe_en_t en;
  hsv2rgb_pkg::front_t   front;
  logic [7:0] red, green, blue;

  // Ready chain: a stage loads when it is empty or its item moves on
  always_comb begin
    rdy[4] = !vld_q[4] || m_axis_tready_i;
    for (int i = 3; i >= 0; i--) begin
      rdy[i] = !vld_q[i] || rdy[i+1];
    end
    for (int i = 0; i < 5; i++) begin
      if (rdy[i]) begin
        vld_d[i] = (i == 0) ? s_axis_tvalid_i : vld_q[(i == 0) ? 0 : i - 1];
      end else begin
        vld_d[i] = vld_q[i];
      end
    end
  end

  assign en = '{s1: rdy[0], s2: rdy[1], s3: rdy[2], s4: rdy[3], s5: rdy[4]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Datapath
  hsv2rgb_front u_front (
    .clk_i   (clk_i),
    .en_i    (en),
    .hue_i   (s_axis_tdata_i[8:0]),
    .sat_i   (s_axis_tdata_i[15:9]),
    .val_i   (s_axis_tdata_i[22:16]),
    .front_o (front)
  );

  hsv2rgb_chan u_chan_red (
    .clk_i   (clk_i),
    .en_i    (en),
    .chan_i  (hsv2rgb_pkg::CH_RED),
    .front_i (front),
    .chan_o  (red)
  );

  hsv2rgb_chan u_chan_green (
    .clk_i   (clk_i),
    .en_i    (en),
    .chan_i  (hsv2rgb_pkg::CH_GREEN),
    .front_i (front),
    .chan_o  (green)
  );

  hsv2rgb_chan u_chan_blue (
    .clk_i   (clk_i),
    .en_i    (en),
    .chan_i  (hsv2rgb_pkg::CH_BLUE),
    .front_i (front),
    .chan_o  (blue)
  );

  assign s_axis_tready_o = rdy[0];
  assign m_axis_tvalid_o = vld_q[4];
  assign m_axis_tdata_o  = {blue, green, red};

  // Checks
  `HSV_ASSERT_ALWAYS(a_empty_out_ready, !m_axis_tvalid_o |-> s_axis_tready_o, "input stalled with empty output")
  `HSV_ASSERT(a_full_stall, (&vld_q && !m_axis_tready_i) |-> !s_axis_tready_o, "ready high with full stalled pipe")
  `HSV_ASSERT(a_last_stage_fill, (rdy[4] && vld_q[3]) |=> m_axis_tvalid_o, "item lost before output register")

endmodule

[sim/hsv_to_rgb_converter_tb.sv]
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_tb
// Self-checking stream testbench for the HSV to RGB converter.
// ----------------------------------------------------------------------------
// A queue of colors is filled up front: a short directed set covering the
// sector edges, field extremes and out-of-range inputs, then random colors,
// mostly in the valid range. A clocked driver sends them with random gaps and
// the monitor takes results with random stalls. Every input transfer is run
// through an integer predictor, and each output transfer is compared per
// channel against the oldest prediction.

module hsv_to_rgb_converter_tb;

  localparam int unsigned NUM_RANDOM  = 1500;
  localparam int unsigned IDLE_LIMIT  = 200;  // cycles with no transfer at all
  localparam int unsigned DRAIN_CYCLES = 20;  // pipeline latency plus margin

  // Color in, packed like s_axis_tdata_i without the pad bit
  typedef struct packed {
    logic [6:0] val_pct;
    logic [6:0] sat_pct;
    logic [8:0] hue_deg;
  } hsv_t;

  // Color out, packed like m_axis_tdata_o
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  logic        clk_i;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i  = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;

  hsv_t        colors_to_send[$];
  rgb_t        rgb_expected[$];
  int unsigned mismatches = 0;

  hsv_to_rgb_converter u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // Exact integer conversion, all terms in units of 1/600000
  function automatic rgb_t predict_rgb(hsv_t c);
    int unsigned          h, s, v, hm, k;
    int unsigned          chroma, second, offset;
    int unsigned          r, g, b;
    hsv2rgb_pkg::sector_e sec;
    rgb_t                 o;
    h = c.hue_deg;
    s = c.sat_pct;
    v = c.val_pct;
    o = '0;
    if (h > hsv2rgb_pkg::HUE_MAX || s > hsv2rgb_pkg::PCT_MAX ||
        v > hsv2rgb_pkg::PCT_MAX) begin
      return o;
    end
    hm     = h % 120;
    k      = (hm >= 60) ? 120 - hm : hm;
    chroma = s * v * 60;
    second = s * v * k;
    offset = v * (100 - s) * 60;
    // 300..360 all land in the last sector
    if (h < 60)       sec = hsv2rgb_pkg::SEC_R_Y;
    else if (h < 120) sec = hsv2rgb_pkg::SEC_Y_G;
    else if (h < 180) sec = hsv2rgb_pkg::SEC_G_C;
    else if (h < 240) sec = hsv2rgb_pkg::SEC_C_B;
    else if (h < 300) sec = hsv2rgb_pkg::SEC_B_M;
    else              sec = hsv2rgb_pkg::SEC_M_R;
    case (sec)
      hsv2rgb_pkg::SEC_R_Y: begin r = chroma; g = second; b = 0;      end
      hsv2rgb_pkg::SEC_Y_G: begin r = second; g = chroma; b = 0;      end
      hsv2rgb_pkg::SEC_G_C: begin r = 0;      g = chroma; b = second; end
      hsv2rgb_pkg::SEC_C_B: begin r = 0;      g = second; b = chroma; end
      hsv2rgb_pkg::SEC_B_M: begin r = second; g = 0;      b = chroma; end
      default:              begin r = chroma; g = 0;      b = second; end
    endcase
    o.red   = 8'(((r + offset) * 255) / 600000);
    o.green = 8'(((g + offset) * 255) / 600000);
    o.blue  = 8'(((b + offset) * 255) / 600000);
    return o;
  endfunction

  // Mostly valid colors, some on edges, some anywhere in the field range
  function automatic hsv_t random_hsv();
    hsv_t        c;
    int unsigned edges[13];
    int unsigned pcts[4];
    edges = '{0, 59, 60, 119, 120, 179, 180, 239, 240, 299, 300, 359, 360};
    pcts  = '{0, 1, 99, 100};
    case ($urandom_range(0, 9))
      7: begin
        c.hue_deg = 9'(edges[$urandom_range(0, 12)]);
        c.sat_pct = 7'(pcts[$urandom_range(0, 3)]);
        c.val_pct = 7'(pcts[$urandom_range(0, 3)]);
      end
      8, 9: begin
        c.hue_deg = 9'($urandom_range(0, 511));
        c.sat_pct = 7'($urandom_range(0, 127));
        c.val_pct = 7'($urandom_range(0, 127));
      end
      default: begin
        c.hue_deg = 9'($urandom_range(0, 360));
        c.sat_pct = 7'($urandom_range(0, 100));
        c.val_pct = 7'($urandom_range(0, 100));
      end
    endcase
    return c;
  endfunction

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Input driver: one color per transfer, random gap after each
  int unsigned send_gap    = 0;
  logic        send_steady = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
      send_gap        <= 0;
      send_steady     <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        rgb_expected.push_back(predict_rgb(hsv_t'(s_axis_tdata_i[22:0])));
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (send_gap != 0) begin
          send_gap        <= send_gap - 1;
          s_axis_tvalid_i <= 1'b0;
        end else if (colors_to_send.size() != 0) begin
          s_axis_tdata_i  <= {1'b0, colors_to_send.pop_front()};
          s_axis_tvalid_i <= 1'b1;
          send_gap        <= send_steady ? 0 : $urandom_range(0, 7);
          // switch between gappy and back-to-back stretches now and then
          if ($urandom_range(0, 47) == 0) send_steady <= !send_steady;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor: check each result, then stall a random number of cycles
  int unsigned take_stall  = 0;
  logic        take_steady = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    rgb_t got;
    rgb_t want;
    int unsigned d;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      take_stall      <= 0;
      take_steady     <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = rgb_t'(m_axis_tdata_o);
        if (rgb_expected.size() == 0) begin
          $error("unexpected result: red %0d green %0d blue %0d",
                 got.red, got.green, got.blue);
          mismatches++;
        end else begin
          want = rgb_expected.pop_front();
          if (got.red !== want.red) begin
            $error("red mismatch: expected %0d, actual %0d", want.red, got.red);
            mismatches++;
          end
          if (got.green !== want.green) begin
            $error("green mismatch: expected %0d, actual %0d", want.green, got.green);
            mismatches++;
          end
          if (got.blue !== want.blue) begin
            $error("blue mismatch: expected %0d, actual %0d", want.blue, got.blue);
            mismatches++;
          end
        end
        d = take_steady ? 0 : $urandom_range(0, 7);
        m_axis_tready_i <= (d == 0);
        take_stall      <= (d == 0) ? 0 : d - 1;
        if ($urandom_range(0, 47) == 0) take_steady <= !take_steady;
      end else if (take_stall != 0) begin
        take_stall      <= take_stall - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Watchdog: no transfer on either side for too long
  int unsigned idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("hsv_to_rgb_converter_tb: FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    hsv_t c;
    int unsigned edges[13];
    edges = '{0, 59, 60, 119, 120, 179, 180, 239, 240, 299, 300, 359, 360};

    // sector edges at full saturation and value
    foreach (edges[i]) begin
      c.hue_deg = 9'(edges[i]);
      c.sat_pct = 7'd100;
      c.val_pct = 7'd100;
      colors_to_send.push_back(c);
    end
    // field extremes, black, white, and each out-of-range field
    colors_to_send.push_back('{val_pct: 7'd0,   sat_pct: 7'd0,   hue_deg: 9'd0});
    colors_to_send.push_back('{val_pct: 7'd100, sat_pct: 7'd0,   hue_deg: 9'd200});
    colors_to_send.push_back('{val_pct: 7'd127, sat_pct: 7'd127, hue_deg: 9'd511});
    colors_to_send.push_back('{val_pct: 7'd100, sat_pct: 7'd100, hue_deg: 9'd361});
    colors_to_send.push_back('{val_pct: 7'd50,  sat_pct: 7'd101, hue_deg: 9'd30});
    colors_to_send.push_back('{val_pct: 7'd101, sat_pct: 7'd50,  hue_deg: 9'd30});
    colors_to_send.push_back('{val_pct: 7'd75,  sat_pct: 7'd50,  hue_deg: 9'd30});
    colors_to_send.push_back('{val_pct: 7'd1,   sat_pct: 7'd1,   hue_deg: 9'd90});
    colors_to_send.push_back('{val_pct: 7'd100, sat_pct: 7'd37,  hue_deg: 9'd330});
    colors_to_send.push_back('{val_pct: 7'd0,   sat_pct: 7'd100, hue_deg: 9'd150});
    for (int unsigned n = 0; n < NUM_RANDOM; n++) colors_to_send.push_back(random_hsv());

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // wait for every color to be sent and every result to come back
    do @(posedge clk_i);
    while (colors_to_send.size() != 0 || s_axis_tvalid_i || rgb_expected.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && rgb_expected.size() == 0) begin
      $display("hsv_to_rgb_converter_tb: PASS");
    end else begin
      $display("hsv_to_rgb_converter_tb: FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/hsv2rgb_pkg.sv
sv/hsv2rgb_front.sv
sv/hsv2rgb_chan.sv
sv/hsv_to_rgb_converter.sv
sim/hsv_to_rgb_converter_tb.sv
